### rtl/fud_pkg.sv
`timescale 1ns / 1ps
// Package for the form-urlencoded pair decoder: result and state types,
// code constants and the hex helpers. No dependencies.
package fud_pkg;

  localparam int unsigned MaxRes   = 4;
  localparam int unsigned MaxPuts  = 3;
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);
  localparam int unsigned PutCntW  = $clog2(MaxPuts + 1);

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_MASK = 8'hdf;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       stream_end;
  } fud_res_t;

  typedef struct packed {
    logic [ResCntW-1:0]          count;
    fud_res_t [MaxRes-1:0]       res;
  } fud_bundle_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] held;
    logic       value_part;
  } fud_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= CH_UPPER_A) begin
      t = (c & CASE_MASK) - CH_UPPER_A + 8'd10;
    end else begin
      t = c - CH_ZERO;
    end
    return t[3:0];
  endfunction

endpackage

### rtl/fud_in_if.sv
`timescale 1ns / 1ps
// Request channel for raw encoded bytes: valid/ready plus payload.
// No dependencies.
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

### rtl/fud_out_if.sv
`timescale 1ns / 1ps
// Request channel for decoded results: valid/ready plus payload.
// No dependencies.
interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_run_end;
  logic       out_stream_end;

  modport source (output valid, output out_byte, output out_kind,
                  output out_run_end, output out_stream_end, input ready);
  modport sink (input valid, input out_byte, input out_kind,
                input out_run_end, input out_stream_end, output ready);
endinterface

### rtl/fud_decode.sv
`timescale 1ns / 1ps
// Combinational decode of one raw byte against the escape/pair state.
// Depends on fud_pkg.
module fud_decode (
  input  logic [7:0]          raw_byte,
  input  logic                raw_last,
  input  fud_pkg::fud_state_t st,
  output fud_pkg::fud_state_t st_nxt,
  output fud_pkg::fud_bundle_t bundle
);
  import fud_pkg::*;

  always_comb begin
    logic [7:0]         b;
    logic [1:0]         ph;
    logic [7:0]         hd;
    logic               vp;
    logic [7:0]         put_b [MaxPuts];
    logic [PutCntW-1:0] put_n;
    logic [ResCntW-1:0] n;

    b     = raw_byte;
    ph    = st.phase;
    hd    = st.held;
    vp    = st.value_part;
    put_n = '0;
    n     = '0;
    for (int i = 0; i < MaxPuts; i++) put_b[i] = '0;
    bundle = '0;

    // Collect the decoded bytes in order.
    if (raw_byte == CH_AMP) begin
      if (ph == PH_PCT || ph == PH_DIG) begin
        put_b[put_n] = CH_PCT;
        put_n = put_n + 1'b1;
      end
      if (ph == PH_DIG) begin
        put_b[put_n] = hd;
        put_n = put_n + 1'b1;
      end
      ph = PH_IDLE;
      hd = '0;
    end else begin
      if (b == CH_PLUS) b = CH_SPACE;
      case (ph)
        PH_PCT: begin
          if (is_hex(b)) begin
            hd = b;
            ph = PH_DIG;
          end else begin
            ph = PH_IDLE;
            put_b[put_n] = CH_PCT;
            put_n = put_n + 1'b1;
            if (b == CH_PCT) begin
              ph = PH_PCT;
            end else begin
              put_b[put_n] = b;
              put_n = put_n + 1'b1;
            end
          end
        end
        PH_DIG: begin
          if (is_hex(b)) begin
            put_b[put_n] = {hex_val(hd), hex_val(b)};
            put_n = put_n + 1'b1;
          end else begin
            put_b[put_n] = CH_PCT;
            put_n = put_n + 1'b1;
            put_b[put_n] = hd;
            put_n = put_n + 1'b1;
          end
          ph = PH_IDLE;
          hd = '0;
          if (!is_hex(b)) begin
            if (b == CH_PCT) begin
              ph = PH_PCT;
            end else begin
              put_b[put_n] = b;
              put_n = put_n + 1'b1;
            end
          end
        end
        default: begin
          ph = PH_IDLE;
          if (b == CH_PCT) begin
            ph = PH_PCT;
          end else begin
            put_b[put_n] = b;
            put_n = put_n + 1'b1;
          end
        end
      endcase
      // Flush a pending escape at stream end.
      if (raw_last) begin
        if (ph == PH_PCT || ph == PH_DIG) begin
          put_b[put_n] = CH_PCT;
          put_n = put_n + 1'b1;
        end
        if (ph == PH_DIG) begin
          put_b[put_n] = hd;
          put_n = put_n + 1'b1;
        end
        ph = PH_IDLE;
        hd = '0;
      end
    end

    // The first '=' of a pair switches to the value and is dropped.
    for (int i = 0; i < MaxPuts; i++) begin
      if (PutCntW'(i) < put_n) begin
        if (!vp && put_b[i] == CH_EQ) begin
          vp = 1'b1;
        end else begin
          bundle.res[n[1:0]] = '{data: put_b[i],
                                 kind: (vp ? KIND_VALUE : KIND_NAME),
                                 stream_end: 1'b0};
          n = n + 1'b1;
        end
      end
    end

    if (raw_byte == CH_AMP || raw_last) begin
      bundle.res[n[1:0]] = '{data: 8'h00, kind: KIND_END, stream_end: raw_last};
      n  = n + 1'b1;
      vp = 1'b0;
    end
    bundle.count = n;

    if (raw_last) begin
      st_nxt = '0;
    end else begin
      st_nxt = '{phase: ph, held: hd, value_part: vp};
    end
  end

endmodule

### rtl/fud_serial.sv
`timescale 1ns / 1ps
// Result register: holds and sends results one per cycle while out_ch.ready.
// Depends on fud_pkg and fud_out_if.
module fud_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  fud_pkg::fud_bundle_t bundle,
  output logic                 free,
  fud_out_if.source            out_ch
);
  import fud_pkg::*;

  fud_res_t [MaxRes-1:0]       res_r;
  logic [ResCntW-1:0]          rem_r;
  logic [$clog2(MaxRes)-1:0]   idx_r;
  logic                        out_fire;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign free     = (rem_r == '0) || (rem_r == ResCntW'(1) && out_ch.ready);

  assign out_ch.valid          = (rem_r != '0);
  assign out_ch.out_byte       = res_r[idx_r].data;
  assign out_ch.out_kind       = res_r[idx_r].kind;
  assign out_ch.out_stream_end = res_r[idx_r].stream_end;
  assign out_ch.out_run_end    = (rem_r == ResCntW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      rem_r <= bundle.count;
      idx_r <= '0;
    end else if (out_fire) begin
      rem_r <= rem_r - 1'b1;
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= bundle.res;
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= ResCntW'(MaxRes))
    else $error("result count out of range");

  a_stream_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_stream_end |->
      out_ch.out_kind == KIND_END && out_ch.out_run_end)
    else $error("stream end not on closing end-of-pair");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && rem_r == ResCntW'(1) && !load |=> rem_r == '0)
    else $error("result register did not drain");
`endif

endmodule

### rtl/form_urlencoded_pair_decoder.sv
`timescale 1ns / 1ps
// Form-urlencoded pair decoder, top level. An accepted request is decoded from
// the input register and loaded into the result register once that is free.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_ch is ready; a multi-result byte holds the result register until drained.
// Reset (rst_n low, synchronous) clears the escape and pair state and empties
// both the input and result registers.
module form_urlencoded_pair_decoder (
  input  logic      clk,
  input  logic      rst_n,
  fud_in_if.sink    in_ch,
  fud_out_if.source out_ch
);
  import fud_pkg::*;

  // Input register: takes a request whenever it is empty or drains this cycle,
  // so a new byte can land while results still wait on out_ch.
  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        in_fire;

  // Escape phase, held hex digit and name/value flag.
  fud_state_t  st_r;
  fud_state_t  st_nxt;

  fud_bundle_t bundle;
  logic        free;
  logic        load;

  // Move the held byte into the result register once the previous results
  // are gone (or the last of them leaves this cycle).
  assign load        = in_valid_r && free;
  assign in_ch.ready = !in_valid_r || load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (load) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      // Advance the decode state only when the byte is consumed.
      if (load) st_r <= st_nxt;
    end
  end

  // Payload: no reset needed, qualified by in_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_ch.in_byte;
      in_last_r <= in_ch.in_last;
    end
  end

  fud_decode u_decode (
    .raw_byte (in_byte_r),
    .raw_last (in_last_r),
    .st       (st_r),
    .st_nxt   (st_nxt),
    .bundle   (bundle)
  );

  fud_serial u_serial (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .bundle (bundle),
    .free   (free),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_last_r |=> st_r.phase == PH_IDLE && !st_r.value_part && st_r.held == '0)
    else $error("state not cleared after stream end");

  a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != PH_DIG |-> st_r.held == '0)
    else $error("held digit outside digit phase");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !load |=> in_valid_r && $stable(in_byte_r) && $stable(in_last_r))
    else $error("input register lost a pending byte");
`endif

endmodule
